// ----- rtl/ctq_pkg.sv -----
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared widths, constants, types and rounding helpers for the Euler angle
// to quaternion pipeline.
// ----------------------------------------------------------------------------
package ctq_pkg;

    localparam int ANGLE_BITS   = 16;                 // Q3.(ANGLE_BITS-4) input
    localparam int RESULT_BITS  = 16;                 // Q1.(RESULT_BITS-2) output
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_FRAC  = 30;                 // Q2.30 sine/cosine

    localparam int PHASE_W      = 33;                 // residual angle, Q3.30
    localparam int ANGLE_SHIFT  = PHASE_W - ANGLE_BITS;
    localparam int CS_W         = 32;                 // sine/cosine width
    localparam int PROD1_W      = 2 * CS_W;           // half-angle pair product
    localparam int PAIR_W       = PROD1_W + 1 - CORDIC_FRAC;
    localparam int PROD2_W      = PAIR_W + CS_W;
    localparam int SUM_W        = PROD2_W + 1;
    localparam int RND_SHIFT    = 2 * CORDIC_FRAC - (RESULT_BITS - 2);
    localparam int RND_W        = SUM_W + 1 - RND_SHIFT;

    localparam int LANES        = 3;
    localparam int LANE_YAW     = 0;
    localparam int LANE_PITCH   = 1;
    localparam int LANE_ROLL    = 2;

    localparam int COMPS        = 4;
    localparam int COMP_W       = 0;
    localparam int COMP_X       = 1;
    localparam int COMP_Y       = 2;
    localparam int COMP_Z       = 3;

    localparam logic signed [PHASE_W:0] Q30_PI       = 34'sd3373259426;
    localparam logic signed [PHASE_W:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [PHASE_W:0] Q30_NHALF_PI = -Q30_HALF_PI;
    localparam logic signed [CS_W-1:0]  Q30_GAIN     = 32'sd652032874;

    // CORDIC rotation state for one angle
    typedef struct packed {
        logic signed [PHASE_W-1:0] h;
        logic signed [CS_W-1:0]    x;   // cosine
        logic signed [CS_W-1:0]    y;   // sine
    } lane_t;

    typedef struct packed {
        logic valid;
        logic flip;     // odd number of folded angles: negate the quaternion
    } ctl_t;

    // arctan(2^-i) in Q30
    function automatic logic signed [PHASE_W-1:0] atan_q30(input int i);
        case (i)
            0:       atan_q30 = 33'sh3243F6A8;
            1:       atan_q30 = 33'sh1DAC6705;
            2:       atan_q30 = 33'sh0FADBAFC;
            3:       atan_q30 = 33'sh07F56EA6;
            4:       atan_q30 = 33'sh03FEAB76;
            5:       atan_q30 = 33'sh01FFD55B;
            6:       atan_q30 = 33'sh00FFFAAA;
            7:       atan_q30 = 33'sh007FFF55;
            8:       atan_q30 = 33'sh003FFFEA;
            9:       atan_q30 = 33'sh001FFFFD;
            default: atan_q30 = {{(PHASE_W-1){1'b0}}, 1'b1} << (CORDIC_FRAC - i);
        endcase
    endfunction

    // Round to nearest, halves away from zero, by 2^CORDIC_FRAC.
    // Negative values use ceil((v - half) / 2^n), folded into one add.
    function automatic logic signed [PAIR_W-1:0] round_pair(
        input logic signed [PROD1_W-1:0] v
    );
        logic signed [PROD1_W:0] bias;
        logic signed [PROD1_W:0] t;
        bias = (PROD1_W + 1)'(1) << (CORDIC_FRAC - 1);
        if (v[PROD1_W-1])
        begin
            bias = bias - (PROD1_W + 1)'(1);
        end
        t = {v[PROD1_W-1], v} + bias;
        round_pair = t[PROD1_W:CORDIC_FRAC];
    endfunction

    function automatic logic signed [RND_W-1:0] round_final(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W:0] bias;
        logic signed [SUM_W:0] t;
        bias = (SUM_W + 1)'(1) << (RND_SHIFT - 1);
        if (v[SUM_W-1])
        begin
            bias = bias - (SUM_W + 1)'(1);
        end
        t = {v[SUM_W-1], v} + bias;
        round_final = t[SUM_W:RND_SHIFT];
    endfunction

endpackage

// ----- rtl/ctq_fold.sv -----
// ----------------------------------------------------------------------------
// ctq_fold
// Entry stage: halves each angle into Q30 and folds it into [-pi/2, pi/2],
// loading the CORDIC start vector.
// ----------------------------------------------------------------------------
module ctq_fold (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic signed [ctq_pkg::ANGLE_BITS-1:0]       yaw_angle,
    input  logic signed [ctq_pkg::ANGLE_BITS-1:0]       pitch_angle,
    input  logic signed [ctq_pkg::ANGLE_BITS-1:0]       roll_angle,
    output ctq_pkg::ctl_t                               ctl_out,
    output ctq_pkg::lane_t [ctq_pkg::LANES-1:0]         lane_out
);

    logic signed [ctq_pkg::ANGLE_BITS-1:0]    angle [ctq_pkg::LANES];
    logic [ctq_pkg::LANES-1:0]                neg_next;
    ctq_pkg::lane_t [ctq_pkg::LANES-1:0]      lane_next;
    ctq_pkg::ctl_t                            ctl_reg;
    ctq_pkg::lane_t [ctq_pkg::LANES-1:0]      lane_reg;

    assign angle[ctq_pkg::LANE_YAW]   = yaw_angle;
    assign angle[ctq_pkg::LANE_PITCH] = pitch_angle;
    assign angle[ctq_pkg::LANE_ROLL]  = roll_angle;

    always_comb
    begin
        logic signed [ctq_pkg::PHASE_W-1:0] h0;
        logic signed [ctq_pkg::PHASE_W:0]   hw;
        for (int l = 0; l < ctq_pkg::LANES; l++)
        begin
            // Q3.x input becomes the half angle in Q30 by a plain left shift
            h0 = {angle[l], {ctq_pkg::ANGLE_SHIFT{1'b0}}};
            hw = {h0[ctq_pkg::PHASE_W-1], h0};
            neg_next[l] = 1'b0;
            if (hw > ctq_pkg::Q30_HALF_PI)
            begin
                hw = hw - ctq_pkg::Q30_PI;
                neg_next[l] = 1'b1;
            end
            else if (hw < ctq_pkg::Q30_NHALF_PI)
            begin
                hw = hw + ctq_pkg::Q30_PI;
                neg_next[l] = 1'b1;
            end
            lane_next[l].h = hw[ctq_pkg::PHASE_W-1:0];
            lane_next[l].x = ctq_pkg::Q30_GAIN;
            lane_next[l].y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.valid <= start;
            ctl_reg.flip  <= ^neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign ctl_out  = ctl_reg;
    assign lane_out = lane_reg;

endmodule

// ----- rtl/ctq_cordic.sv -----
// ----------------------------------------------------------------------------
// ctq_cordic
// Unrolled rotation-mode CORDIC, one registered iteration per stage, three
// angle lanes side by side.
// ----------------------------------------------------------------------------
module ctq_cordic (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  ctq_pkg::ctl_t                               ctl_in,
    input  ctq_pkg::lane_t [ctq_pkg::LANES-1:0]         lane_in,
    output ctq_pkg::ctl_t                               ctl_out,
    output ctq_pkg::lane_t [ctq_pkg::LANES-1:0]         lane_out
);

    ctq_pkg::ctl_t                          ctl_reg  [ctq_pkg::CORDIC_STEPS];
    ctq_pkg::lane_t [ctq_pkg::LANES-1:0]    lane_reg [ctq_pkg::CORDIC_STEPS];

    for (genvar i = 0; i < ctq_pkg::CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ctq_pkg::PHASE_W-1:0] ATAN = ctq_pkg::atan_q30(i);

        ctq_pkg::ctl_t                          ctl_cur;
        ctq_pkg::lane_t [ctq_pkg::LANES-1:0]    lane_cur;
        ctq_pkg::lane_t [ctq_pkg::LANES-1:0]    lane_next;

        if (i == 0)
        begin : g_first
            assign ctl_cur  = ctl_in;
            assign lane_cur = lane_in;
        end
        else
        begin : g_rest
            assign ctl_cur  = ctl_reg[i-1];
            assign lane_cur = lane_reg[i-1];
        end

        always_comb
        begin
            for (int l = 0; l < ctq_pkg::LANES; l++)
            begin
                // arithmetic shifts floor toward minus infinity
                if (!lane_cur[l].h[ctq_pkg::PHASE_W-1])
                begin
                    lane_next[l].h = lane_cur[l].h - ATAN;
                    lane_next[l].x = lane_cur[l].x - (lane_cur[l].y >>> i);
                    lane_next[l].y = lane_cur[l].y + (lane_cur[l].x >>> i);
                end
                else
                begin
                    lane_next[l].h = lane_cur[l].h + ATAN;
                    lane_next[l].x = lane_cur[l].x + (lane_cur[l].y >>> i);
                    lane_next[l].y = lane_cur[l].y - (lane_cur[l].x >>> i);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else
            begin
                ctl_reg[i] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            lane_reg[i] <= lane_next;
        end
    end

    assign ctl_out  = ctl_reg[ctq_pkg::CORDIC_STEPS-1];
    assign lane_out = lane_reg[ctq_pkg::CORDIC_STEPS-1];

endmodule

// ----- rtl/ctq_combine.sv -----
// ----------------------------------------------------------------------------
// ctq_combine
// Forms the ZYX quaternion sums from the half-angle sines and cosines:
// roll/pitch pair products, rounding to Q30, products with yaw, then sums.
// ----------------------------------------------------------------------------
module ctq_combine (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  ctq_pkg::ctl_t                               ctl_in,
    input  ctq_pkg::lane_t [ctq_pkg::LANES-1:0]         lane_in,
    output ctq_pkg::ctl_t                               ctl_out,
    output logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::SUM_W-1:0] sum_out
);

    // pair product order: crcp, srsp, srcp, crsp
    localparam int P_CRCP = 0;
    localparam int P_SRSP = 1;
    localparam int P_SRCP = 2;
    localparam int P_CRSP = 3;
    localparam int PAIRS  = 4;

    ctq_pkg::ctl_t  ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic signed [ctq_pkg::PROD1_W-1:0] prod1_reg [PAIRS];
    logic signed [ctq_pkg::CS_W-1:0]    cy1_reg, sy1_reg, cy2_reg, sy2_reg;
    logic signed [ctq_pkg::PAIR_W-1:0]  pair_reg  [PAIRS];

    // second products: [pair][0] times cy, [pair][1] times sy
    logic signed [ctq_pkg::PROD2_W-1:0] prod2_reg [PAIRS][2];
    logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::SUM_W-1:0] sum_reg;

    logic signed [ctq_pkg::CS_W-1:0] cr, sr, cp, sp;

    assign cr = lane_in[ctq_pkg::LANE_ROLL].x;
    assign sr = lane_in[ctq_pkg::LANE_ROLL].y;
    assign cp = lane_in[ctq_pkg::LANE_PITCH].x;
    assign sp = lane_in[ctq_pkg::LANE_PITCH].y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: roll x pitch
        prod1_reg[P_CRCP] <= ctq_pkg::PROD1_W'(cr) * ctq_pkg::PROD1_W'(cp);
        prod1_reg[P_SRSP] <= ctq_pkg::PROD1_W'(sr) * ctq_pkg::PROD1_W'(sp);
        prod1_reg[P_SRCP] <= ctq_pkg::PROD1_W'(sr) * ctq_pkg::PROD1_W'(cp);
        prod1_reg[P_CRSP] <= ctq_pkg::PROD1_W'(cr) * ctq_pkg::PROD1_W'(sp);
        cy1_reg <= lane_in[ctq_pkg::LANE_YAW].x;
        sy1_reg <= lane_in[ctq_pkg::LANE_YAW].y;

        // stage 2: back to Q30
        for (int p = 0; p < PAIRS; p++)
        begin
            pair_reg[p] <= ctq_pkg::round_pair(prod1_reg[p]);
        end
        cy2_reg <= cy1_reg;
        sy2_reg <= sy1_reg;

        // stage 3: times yaw, exact in Q60
        for (int p = 0; p < PAIRS; p++)
        begin
            prod2_reg[p][0] <= ctq_pkg::PROD2_W'(pair_reg[p]) * ctq_pkg::PROD2_W'(cy2_reg);
            prod2_reg[p][1] <= ctq_pkg::PROD2_W'(pair_reg[p]) * ctq_pkg::PROD2_W'(sy2_reg);
        end

        // stage 4: component sums
        sum_reg[ctq_pkg::COMP_W] <= ctq_pkg::SUM_W'(prod2_reg[P_CRCP][0])
                                  + ctq_pkg::SUM_W'(prod2_reg[P_SRSP][1]);
        sum_reg[ctq_pkg::COMP_X] <= ctq_pkg::SUM_W'(prod2_reg[P_SRCP][0])
                                  - ctq_pkg::SUM_W'(prod2_reg[P_CRSP][1]);
        sum_reg[ctq_pkg::COMP_Y] <= ctq_pkg::SUM_W'(prod2_reg[P_CRSP][0])
                                  + ctq_pkg::SUM_W'(prod2_reg[P_SRCP][1]);
        sum_reg[ctq_pkg::COMP_Z] <= ctq_pkg::SUM_W'(prod2_reg[P_CRCP][1])
                                  - ctq_pkg::SUM_W'(prod2_reg[P_SRSP][0]);
    end

    assign ctl_out = ctl4_reg;
    assign sum_out = sum_reg;

endmodule

// ----- rtl/ctq_finish.sv -----
// ----------------------------------------------------------------------------
// ctq_finish
// Rounds each Q60 sum to the result format, saturates to +-1.0 and applies
// the fold sign.
// ----------------------------------------------------------------------------
module ctq_finish (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  ctq_pkg::ctl_t                                           ctl_in,
    input  logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::SUM_W-1:0]    sum_in,
    output logic                                                    done,
    output logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::RESULT_BITS-1:0] quat
);

    localparam logic signed [ctq_pkg::RND_W-1:0] ONE  =
        ctq_pkg::RND_W'(1) << (ctq_pkg::RESULT_BITS - 2);
    localparam logic signed [ctq_pkg::RND_W-1:0] NONE = -ONE;

    ctq_pkg::ctl_t                                          ctl_reg;
    logic                                                   done_reg;
    logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::RND_W-1:0]   rnd_reg;
    logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::RESULT_BITS-1:0] quat_reg;
    logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::RESULT_BITS-1:0] quat_next;

    always_comb
    begin
        logic signed [ctq_pkg::RND_W-1:0] sat;
        for (int c = 0; c < ctq_pkg::COMPS; c++)
        begin
            sat = rnd_reg[c];
            if (sat > ONE)
            begin
                sat = ONE;
            end
            else if (sat < NONE)
            begin
                sat = NONE;
            end
            // rounding and clamp are symmetric, so the sign comes last
            if (ctl_reg.flip)
            begin
                sat = -sat;
            end
            quat_next[c] = sat[ctq_pkg::RESULT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            done_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < ctq_pkg::COMPS; c++)
        begin
            rnd_reg[c] <= ctq_pkg::round_final(sum_in[c]);
        end
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

endmodule

// ----- rtl/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Pipeline: start is taken into 1 fold, 30 CORDIC, 4 multiply/sum and
//   2 round/saturate stages, at whose end done and the quaternion appear.
// Throughput: one transaction per cycle; busy is always low.
// Reset clears only the control bits (valid and flip) of the pipeline; done is low after reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [ctq_pkg::ANGLE_BITS-1:0]   yaw_angle,
    input  logic signed [ctq_pkg::ANGLE_BITS-1:0]   pitch_angle,
    input  logic signed [ctq_pkg::ANGLE_BITS-1:0]   roll_angle,
    output logic                                    done,
    output logic signed [ctq_pkg::RESULT_BITS-1:0]  quat_w,
    output logic signed [ctq_pkg::RESULT_BITS-1:0]  quat_x,
    output logic signed [ctq_pkg::RESULT_BITS-1:0]  quat_y,
    output logic signed [ctq_pkg::RESULT_BITS-1:0]  quat_z
);

    ctq_pkg::ctl_t                          fold_ctl, cordic_ctl, comb_ctl;
    ctq_pkg::lane_t [ctq_pkg::LANES-1:0]    fold_lane, cordic_lane;
    logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::SUM_W-1:0]       comb_sum;
    logic signed [ctq_pkg::COMPS-1:0][ctq_pkg::RESULT_BITS-1:0] quat;

    // fully pipelined: a new transaction every cycle
    assign busy = 1'b0;

    ctq_fold u_fold (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .yaw_angle   (yaw_angle),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .ctl_out     (fold_ctl),
        .lane_out    (fold_lane)
    );

    ctq_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (fold_ctl),
        .lane_in  (fold_lane),
        .ctl_out  (cordic_ctl),
        .lane_out (cordic_lane)
    );

    ctq_combine u_combine (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (cordic_ctl),
        .lane_in (cordic_lane),
        .ctl_out (comb_ctl),
        .sum_out (comb_sum)
    );

    ctq_finish u_finish (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (comb_ctl),
        .sum_in (comb_sum),
        .done   (done),
        .quat   (quat)
    );

    assign quat_w = quat[ctq_pkg::COMP_W];
    assign quat_x = quat[ctq_pkg::COMP_X];
    assign quat_y = quat[ctq_pkg::COMP_Y];
    assign quat_z = quat[ctq_pkg::COMP_Z];

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for euler_to_quaternion. A queue-fed driver issues yaw,
// pitch and roll transactions with varying pacing. A bit-exact CORDIC
// predictor forms the expected quaternion for each accepted transaction.
// A monitor compares every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ctq_pkg::*;

    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      DRAIN_CYCLES = 40;
    localparam longint  PI_Q30       = 64'sd3373259426;
    localparam longint  HALF_PI_Q30  = 64'sd1686629713;
    localparam longint  GAIN_Q30     = 64'sd652032874;
    localparam int      SINCOS_FRAC  = 30;
    localparam int      ROTATIONS    = 30;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] yaw;
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] roll;
    } angle_set_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] w;
        logic signed [RESULT_BITS-1:0] x;
        logic signed [RESULT_BITS-1:0] y;
        logic signed [RESULT_BITS-1:0] z;
    } quat_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           start       = 1'b0;
    logic signed [ANGLE_BITS-1:0]   yaw_angle   = '0;
    logic signed [ANGLE_BITS-1:0]   pitch_angle = '0;
    logic signed [ANGLE_BITS-1:0]   roll_angle  = '0;
    logic                           busy;
    logic                           done;
    logic signed [RESULT_BITS-1:0]  quat_w;
    logic signed [RESULT_BITS-1:0]  quat_x;
    logic signed [RESULT_BITS-1:0]  quat_y;
    logic signed [RESULT_BITS-1:0]  quat_z;

    angle_set_t angle_queue[$];
    quat_t      quat_expected[$];
    angle_set_t driven_item   = '0;
    int         idle_pct      = 0;
    bit         hold_send     = 1'b0;
    int         fail_count    = 0;
    int         accepted_count = 0;
    int         checked_count = 0;
    int         cycle_count   = 0;

    euler_to_quaternion i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .yaw_angle   (yaw_angle),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .done        (done),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint atan_step(input int k);
        case (k)
            0:       atan_step = 64'h3243F6A8;
            1:       atan_step = 64'h1DAC6705;
            2:       atan_step = 64'h0FADBAFC;
            3:       atan_step = 64'h07F56EA6;
            4:       atan_step = 64'h03FEAB76;
            5:       atan_step = 64'h01FFD55B;
            6:       atan_step = 64'h00FFFAAA;
            7:       atan_step = 64'h007FFF55;
            8:       atan_step = 64'h003FFFEA;
            9:       atan_step = 64'h001FFFFD;
            default: atan_step = longint'(1) << (SINCOS_FRAC - k);
        endcase
    endfunction

    // halves away from zero
    function automatic longint round_half_away(input longint v, input int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    // sine and cosine of half the coded angle, Q30
    function automatic void half_angle_sincos(
        input  logic signed [ANGLE_BITS-1:0] code,
        output longint                       s,
        output longint                       c
    );
        longint phase;
        longint cx;
        longint sy;
        longint nx;
        longint dx;
        longint dy;
        bit     folded;
        phase  = longint'(code) * (longint'(1) << (33 - ANGLE_BITS));
        folded = 1'b0;
        if (phase > HALF_PI_Q30)
        begin
            phase  = phase - PI_Q30;
            folded = 1'b1;
        end
        else if (phase < -HALF_PI_Q30)
        begin
            phase  = phase + PI_Q30;
            folded = 1'b1;
        end
        cx = GAIN_Q30;
        sy = 0;
        for (int k = 0; k < ROTATIONS; k++)
        begin
            dx = sy >>> k;
            dy = cx >>> k;
            if (phase >= 0)
            begin
                nx    = cx - dx;
                sy    = sy + dy;
                phase = phase - atan_step(k);
            end
            else
            begin
                nx    = cx + dx;
                sy    = sy - dy;
                phase = phase + atan_step(k);
            end
            cx = nx;
        end
        c = folded ? -cx : cx;
        s = folded ? -sy : sy;
    endfunction

    function automatic logic signed [RESULT_BITS-1:0] to_result(input longint q60);
        longint one;
        longint v;
        one = longint'(1) << (RESULT_BITS - 2);
        v   = round_half_away(q60, 2 * SINCOS_FRAC - (RESULT_BITS - 2));
        if (v > one)
            v = one;
        if (v < -one)
            v = -one;
        return RESULT_BITS'(v);
    endfunction

    function automatic quat_t predict_quaternion(input angle_set_t a);
        longint s_yaw, c_yaw, s_pitch, c_pitch, s_roll, c_roll;
        longint cc, ss, sc, cs;
        quat_t  q;
        half_angle_sincos(a.yaw,   s_yaw,   c_yaw);
        half_angle_sincos(a.pitch, s_pitch, c_pitch);
        half_angle_sincos(a.roll,  s_roll,  c_roll);
        cc  = round_half_away(c_roll * c_pitch, SINCOS_FRAC);
        ss  = round_half_away(s_roll * s_pitch, SINCOS_FRAC);
        sc  = round_half_away(s_roll * c_pitch, SINCOS_FRAC);
        cs  = round_half_away(c_roll * s_pitch, SINCOS_FRAC);
        q.w = to_result(cc * c_yaw + ss * s_yaw);
        q.x = to_result(sc * c_yaw - cs * s_yaw);
        q.y = to_result(cs * c_yaw + sc * s_yaw);
        q.z = to_result(cc * s_yaw - ss * c_yaw);
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_angles(
        input logic signed [ANGLE_BITS-1:0] y,
        input logic signed [ANGLE_BITS-1:0] p,
        input logic signed [ANGLE_BITS-1:0] r
    );
        angle_set_t a;
        a.yaw   = y;
        a.pitch = p;
        a.roll  = r;
        angle_queue.push_back(a);
    endtask

    // mix of full range, in-range, fold boundary, near zero, extremes and right-angle multiples
    function automatic logic signed [ANGLE_BITS-1:0] random_angle();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            4, 5:    random_angle = ANGLE_BITS'(int'($urandom_range(25736)) - 12868);
            6:       random_angle = ANGLE_BITS'(($urandom_range(1) ? 12868 : -12868)
                                                + int'($urandom_range(16)) - 8);
            7:       random_angle = ANGLE_BITS'(int'($urandom_range(128)) - 64);
            8:
            begin
                case ($urandom_range(3))
                    0:       random_angle = ANGLE_BITS'(-32768);
                    1:       random_angle = ANGLE_BITS'(32767);
                    2:       random_angle = '0;
                    default: random_angle = ANGLE_BITS'(int'($urandom_range(2)) - 1);
                endcase
            end
            9:       random_angle = ANGLE_BITS'(6434 * (int'($urandom_range(8)) - 4)
                                                + int'($urandom_range(8)) - 4);
            default: random_angle = ANGLE_BITS'($urandom);
        endcase
    endfunction

    task automatic wait_all_sent();
        while (angle_queue.size() != 0 || start)
            @(posedge clk);
    endtask

    task automatic wait_all_returned();
        while (quat_expected.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: one transaction per edge with start high and busy low
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        bit         take_next;
        angle_set_t nxt;
        if (rst_n)
        begin
            take_next = 1'b0;
            if (start && !busy)
            begin
                quat_expected.push_back(predict_quaternion(driven_item));
                accepted_count++;
                take_next = 1'b1;
            end
            else if (!start)
            begin
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (angle_queue.size() != 0 && !hold_send
                    && int'($urandom_range(99)) >= idle_pct)
                begin
                    nxt          = angle_queue.pop_front();
                    driven_item <= nxt;
                    yaw_angle   <= nxt.yaw;
                    pitch_angle <= nxt.pitch;
                    roll_angle  <= nxt.roll;
                    start       <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    function automatic void compare_component(
        input string                         name,
        input logic signed [RESULT_BITS-1:0] want,
        input logic signed [RESULT_BITS-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        quat_t want;
        if (rst_n && done)
        begin
            if (quat_expected.size() == 0)
            begin
                $error("result transaction with no pending prediction");
                fail_count++;
            end
            else
            begin
                want = quat_expected.pop_front();
                compare_component("quat_w", want.w, quat_w);
                compare_component("quat_x", want.x, quat_x);
                compare_component("quat_y", want.y, quat_y);
                compare_component("quat_z", want.z, quat_z);
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, fold boundary at +-pi, right angles, bit patterns
        push_angles(0, 0, 0);
        push_angles(32767, 32767, 32767);
        push_angles(-32768, -32768, -32768);
        push_angles(32767, 0, 0);
        push_angles(0, 32767, 0);
        push_angles(0, 0, 32767);
        push_angles(-32768, 0, 0);
        push_angles(0, -32768, 0);
        push_angles(0, 0, -32768);
        push_angles(12867, 0, 0);
        push_angles(12868, 0, 0);
        push_angles(-12867, 0, 0);
        push_angles(-12868, 0, 0);
        push_angles(0, 12868, -12868);
        push_angles(12868, -12867, 12867);
        push_angles(6434, 6434, 6434);
        push_angles(-6434, 6434, -6434);
        push_angles(1, -1, 1);
        push_angles(-1, 1, -1);
        push_angles(32767, -32768, 32767);
        push_angles(16384, -16384, 8192);
        push_angles(21845, -21846, 21845);
        push_angles(-21846, 21845, -21846);
        wait_all_sent();

        // random phases: back to back, sparse sender, moderate gaps, back to back
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct <= 81;
                2:       idle_pct <= 21;
                default: idle_pct <= 0;
            endcase
            for (int n = 0; n < (phase == 3 ? 350 : 400); n++)
                push_angles(random_angle(), random_angle(), random_angle());
            wait_all_sent();
            if (phase == 1)
            begin
                // let the pipeline empty before resuming
                hold_send <= 1'b1;
                wait_all_returned();
                hold_send <= 1'b0;
            end
        end

        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d angle transactions, checked %0d quaternions", accepted_count,
                 checked_count);
        $display("Covered extremes, +-pi folding and four pacing phases, %0d mismatches",
                 fail_count);
        if (fail_count == 0 && quat_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
